>>> rtl/core/vertical_tile_scroll_refresher_core_macros.svh
// Assertion macros shared by the vertical tile scroll refresher RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef VERTICAL_TILE_SCROLL_REFRESHER_CORE_MACROS_SVH
`define VERTICAL_TILE_SCROLL_REFRESHER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VTSR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VTSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/vtsr_pkg.sv
// Package for the vertical tile scroll refresher: geometry constants, codes,
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package vtsr_pkg;

    localparam int MAP_DEPTH     = 4096;
    localparam int BUFFER_ROWS   = 288;
    localparam int TILE_SIZE     = 16;
    localparam int PLANES        = 4;
    localparam int VISIBLE_ROWS  = 256;
    localparam int TILES_PER_ROW = 20;

    localparam int SHEET_WIDTH         = 320;
    localparam int SHEET_BYTES_PER_ROW = SHEET_WIDTH / 8;
    localparam int SHEET_TILES_PER_ROW = SHEET_WIDTH / TILE_SIZE;
    localparam int RING_BYTES_PER_ROW  = TILES_PER_ROW * TILE_SIZE / 8;
    localparam int RING_TILE_ROWS      = BUFFER_ROWS / TILE_SIZE;

    localparam int SPLIT_RAW = 2 * TILE_SIZE - TILES_PER_ROW;
    localparam int SPLIT     = (SPLIT_RAW < 0) ? 0 :
                               ((SPLIT_RAW > TILE_SIZE) ? TILE_SIZE : SPLIT_RAW);

    localparam int TILE_SHIFT = $clog2(TILE_SIZE);
    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int POS_W      = 16;
    localparam int BROW_W     = $clog2(BUFFER_ROWS);
    localparam int ROW_W      = $clog2(RING_TILE_ROWS + (1 << (POS_W - TILE_SHIFT)));
    localparam int COL_W      = $clog2(2 * TILE_SIZE);
    localparam int STEP_W     = TILE_SHIFT;
    localparam int LIM_W      = 20;
    localparam int LINE_W     = $clog2(BUFFER_ROWS + 256);

    localparam int CFG_W   = 13;
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 12;
    localparam int TILE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int OFS_W   = 16;

    localparam int RECIP_SHIFT = 16;
    localparam int SHEET_RECIP = (1 << RECIP_SHIFT) / SHEET_TILES_PER_ROW;

    localparam int SRC_ROW_BYTES = TILE_SIZE * PLANES * SHEET_BYTES_PER_ROW;
    localparam int DST_ROW_BYTES = TILE_SIZE * PLANES * RING_BYTES_PER_ROW;
    localparam int TOP_LINE_BYTES = RING_BYTES_PER_ROW * PLANES;

    localparam logic [OFS_W-1:0] XBYTE_MASK    = 16'hFFFE;
    localparam logic [OFS_W-1:0] WAIT_PLAIN    = 16'h0001;
    localparam logic [OFS_W-1:0] WAIT_PAST_END = 16'hFFDF;
    localparam logic [7:0]       WAIT_LOW_TAIL = 8'h01;
    localparam int               LINE_WRAP     = 256;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLIT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISPLAY = 2'd2;

    localparam logic [1:0] CFG_MAP_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_WINDOW_START = 2'd2;

    typedef struct packed {
        logic accept;
        logic index_en;
        logic read_en;
        logic scale_en;
        logic emit_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic blit;
        logic second;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/vtsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the tile map store.
`default_nettype none

module vtsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/vtsr_ctrl.sv
// Controller state machine of the vertical tile scroll refresher.
// Depends on vtsr_pkg for the command and status structs.
`default_nettype none

module vtsr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire vtsr_pkg::dp_status_t st,
    output vtsr_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INDEX = 5'b00010,
        S_READ  = 5'b00100,
        S_SCALE = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = st.blit ? S_INDEX : S_EMIT;
                end
            end
            S_INDEX:
            begin
                cmd.index_en = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_en = 1'b1;
                    state_next  = st.second ? S_READ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/vtsr_datapath.sv
// Datapath of the vertical tile scroll refresher: configuration, scroll state,
// map store, offset arithmetic and output register. Uses vtsr_pkg and vtsr_ram.
`default_nettype none

module vtsr_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vtsr_pkg::ctrl_cmd_t           cmd,
    output vtsr_pkg::dp_status_t               st,
    input  wire logic                          cfg_valid,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [vtsr_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic [vtsr_pkg::CMD_W-1:0]    command,
    input  wire logic [vtsr_pkg::ADDR_W-1:0]   map_address,
    input  wire logic [vtsr_pkg::TILE_W-1:0]   map_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [vtsr_pkg::KIND_W-1:0]   kind,
    output logic      [vtsr_pkg::OFS_W-1:0]    source_offset,
    output logic      [vtsr_pkg::OFS_W-1:0]    dest_offset,
    output logic      [vtsr_pkg::OFS_W-1:0]    top_offset,
    output logic      [vtsr_pkg::OFS_W-1:0]    first_wait_high,
    output logic      [vtsr_pkg::OFS_W-1:0]    first_wait_low,
    output logic      [vtsr_pkg::OFS_W-1:0]    second_wait_high,
    output logic      [vtsr_pkg::OFS_W-1:0]    second_wait_low,
    output logic                               last
);

    logic [vtsr_pkg::CFG_W-1:0]  width_reg;
    logic [vtsr_pkg::CFG_W-1:0]  height_reg;
    logic [7:0]                  wsl_reg;
    logic [vtsr_pkg::POS_W-1:0]  pos_reg;
    logic [vtsr_pkg::POS_W-1:0]  pos_next;
    logic [vtsr_pkg::BROW_W-1:0] brow_reg;
    logic [vtsr_pkg::BROW_W-1:0] brow_next;
    logic [vtsr_pkg::KIND_W-1:0] res_kind_reg;
    logic                        second_reg;
    logic                        out_valid_reg;

    logic [vtsr_pkg::ROW_W-1:0]  maprow_reg;
    logic [vtsr_pkg::ROW_W-1:0]  maprow_next;
    logic [vtsr_pkg::BROW_W-1:0] rrow_reg;
    logic [vtsr_pkg::BROW_W-1:0] rrow_next;
    logic [vtsr_pkg::COL_W-1:0]  col_reg;
    logic [vtsr_pkg::COL_W-1:0]  col_next;
    logic                        two_next;
    logic [vtsr_pkg::MAP_AW-1:0] prod_reg;
    logic [vtsr_pkg::OFS_W-1:0]  dst_base_reg;
    logic [vtsr_pkg::TILE_W-1:0] tile_reg;
    logic [vtsr_pkg::TILE_W-1:0] q0_reg;

    logic [vtsr_pkg::KIND_W-1:0] kind_reg;
    logic [vtsr_pkg::OFS_W-1:0]  src_reg;
    logic [vtsr_pkg::OFS_W-1:0]  dst_reg;
    logic [vtsr_pkg::OFS_W-1:0]  top_reg;
    logic [vtsr_pkg::OFS_W-1:0]  fh_reg;
    logic [vtsr_pkg::OFS_W-1:0]  fl_reg;
    logic [vtsr_pkg::OFS_W-1:0]  sh_reg;
    logic [vtsr_pkg::OFS_W-1:0]  sl_reg;
    logic                        last_reg;

    logic                        move_up;
    logic                        move_down;
    logic                        down_blocked;
    logic [vtsr_pkg::POS_W-1:0]  pos_dec;
    logic [vtsr_pkg::STEP_W-1:0] step;
    logic [vtsr_pkg::COL_W-1:0]  step_c;
    logic                        is_move;
    logic                        is_blit;

    logic [vtsr_pkg::ROW_W+vtsr_pkg::CFG_W-1:0] prod_full;
    logic [vtsr_pkg::MAP_AW-1:0] raddr;
    logic [vtsr_pkg::TILE_W-1:0] rdata;
    logic [vtsr_pkg::TILE_W+vtsr_pkg::RECIP_SHIFT-1:0] recip_prod;

    logic [vtsr_pkg::TILE_W-1:0] rem_raw;
    logic                        rem_fix;
    logic [vtsr_pkg::TILE_W-1:0] rem;
    logic [vtsr_pkg::TILE_W-1:0] quo;
    logic [vtsr_pkg::OFS_W-1:0]  src_val;
    logic [vtsr_pkg::OFS_W-1:0]  dst_val;

    logic [vtsr_pkg::BROW_W:0]   yo_sum;
    logic [vtsr_pkg::BROW_W-1:0] yo;
    logic [vtsr_pkg::LINE_W-1:0] line;
    logic [vtsr_pkg::LINE_W-1:0] line_m1;
    logic [vtsr_pkg::OFS_W-1:0]  top_val;

    logic                        wr_en;

    // Scroll decisions for the item at the input.
    always_comb
    begin
        pos_dec      = pos_reg - 1'b1;
        down_blocked = (pos_reg == '1) ||
                       (vtsr_pkg::LIM_W'(pos_reg) +
                        vtsr_pkg::LIM_W'(vtsr_pkg::VISIBLE_ROWS + vtsr_pkg::TILE_SIZE) >=
                        (vtsr_pkg::LIM_W'(height_reg) << vtsr_pkg::TILE_SHIFT));
        move_up      = (command == vtsr_pkg::CMD_UP) && (pos_reg != '0);
        move_down    = (command == vtsr_pkg::CMD_DOWN) && !down_blocked;
        is_move      = move_up || move_down;

        pos_next    = pos_reg;
        brow_next   = brow_reg;
        rrow_next   = brow_reg;
        maprow_next = vtsr_pkg::ROW_W'(vtsr_pkg::RING_TILE_ROWS) +
                      vtsr_pkg::ROW_W'(pos_reg >> vtsr_pkg::TILE_SHIFT);
        step        = pos_reg[vtsr_pkg::STEP_W-1:0];
        if (move_up)
        begin
            pos_next    = pos_dec;
            brow_next   = (brow_reg == '0) ? vtsr_pkg::BROW_W'(vtsr_pkg::BUFFER_ROWS - 1)
                                           : brow_reg - 1'b1;
            rrow_next   = brow_next;
            maprow_next = vtsr_pkg::ROW_W'(pos_dec >> vtsr_pkg::TILE_SHIFT);
            step        = pos_dec[vtsr_pkg::STEP_W-1:0];
        end
        else if (move_down)
        begin
            pos_next  = pos_reg + 1'b1;
            brow_next = (brow_reg == vtsr_pkg::BROW_W'(vtsr_pkg::BUFFER_ROWS - 1)) ? '0
                                                                              : brow_reg + 1'b1;
        end

        step_c   = vtsr_pkg::COL_W'(step);
        two_next = (step_c >= vtsr_pkg::COL_W'(vtsr_pkg::SPLIT));
        col_next = two_next ? ((step_c << 1) - vtsr_pkg::COL_W'(vtsr_pkg::SPLIT)) : step_c;
    end

    assign is_blit = is_move;
    assign wr_en   = cmd.accept && (command == vtsr_pkg::CMD_WRITE);
    assign raddr   = prod_reg + vtsr_pkg::MAP_AW'(col_reg);

    vtsr_ram #(
        .WIDTH (vtsr_pkg::TILE_W),
        .DEPTH (vtsr_pkg::MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (vtsr_pkg::MAP_AW'(map_address)),
        .wdata (map_value),
        .re    (cmd.read_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign prod_full  = (vtsr_pkg::ROW_W + vtsr_pkg::CFG_W)'(maprow_reg) *
                        (vtsr_pkg::ROW_W + vtsr_pkg::CFG_W)'(width_reg);
    assign recip_prod = (vtsr_pkg::TILE_W + vtsr_pkg::RECIP_SHIFT)'(rdata) *
                        (vtsr_pkg::TILE_W + vtsr_pkg::RECIP_SHIFT)'(vtsr_pkg::SHEET_RECIP);

    // Tile number to sheet offset; the reciprocal estimate is at most one low.
    always_comb
    begin
        rem_raw = tile_reg -
                  vtsr_pkg::TILE_W'(q0_reg * vtsr_pkg::TILE_W'(vtsr_pkg::SHEET_TILES_PER_ROW));
        rem_fix = (rem_raw >= vtsr_pkg::TILE_W'(vtsr_pkg::SHEET_TILES_PER_ROW));
        rem     = rem_fix ? rem_raw - vtsr_pkg::TILE_W'(vtsr_pkg::SHEET_TILES_PER_ROW) : rem_raw;
        quo     = q0_reg + vtsr_pkg::TILE_W'(rem_fix);
        src_val = vtsr_pkg::OFS_W'(32'(rem) * (vtsr_pkg::TILE_SIZE / 8)) +
                  vtsr_pkg::OFS_W'(32'(quo) * vtsr_pkg::SRC_ROW_BYTES);
        dst_val = dst_base_reg +
                  (vtsr_pkg::OFS_W'((32'(col_reg) * vtsr_pkg::TILE_SIZE) >> 3) &
                   vtsr_pkg::XBYTE_MASK);
    end

    // Display split. The low wait words carry the line number modulo 256, less one
    // for the first, in every case; only the high words depend on where the wrap falls.
    always_comb
    begin
        yo_sum  = (vtsr_pkg::BROW_W + 1)'(brow_reg) +
                  (vtsr_pkg::BROW_W + 1)'(vtsr_pkg::TILE_SIZE);
        yo      = (yo_sum >= (vtsr_pkg::BROW_W + 1)'(vtsr_pkg::BUFFER_ROWS)) ?
                  vtsr_pkg::BROW_W'(yo_sum - (vtsr_pkg::BROW_W + 1)'(vtsr_pkg::BUFFER_ROWS)) :
                  vtsr_pkg::BROW_W'(yo_sum);
        top_val = vtsr_pkg::OFS_W'(32'(yo) * vtsr_pkg::TOP_LINE_BYTES);
        line    = vtsr_pkg::LINE_W'(vtsr_pkg::BUFFER_ROWS) - vtsr_pkg::LINE_W'(yo) +
                  vtsr_pkg::LINE_W'(wsl_reg);
        line_m1 = line - 1'b1;
    end

    assign st.blit     = is_blit;
    assign st.second   = second_reg;
    assign st.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= vtsr_pkg::CFG_W'(20);
            height_reg    <= vtsr_pkg::CFG_W'(16);
            wsl_reg       <= 8'd44;
            pos_reg       <= '0;
            brow_reg      <= '0;
            res_kind_reg  <= vtsr_pkg::KIND_ACK;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    vtsr_pkg::CFG_MAP_WIDTH:    width_reg  <= cfg_data;
                    vtsr_pkg::CFG_MAP_HEIGHT:   height_reg <= cfg_data;
                    vtsr_pkg::CFG_WINDOW_START: wsl_reg    <= cfg_data[7:0];
                    default:                    ;
                endcase
            end
            if (cmd.accept)
            begin
                pos_reg    <= pos_next;
                brow_reg   <= brow_next;
                second_reg <= is_blit && two_next;
                if (command == vtsr_pkg::CMD_FRAME)
                begin
                    res_kind_reg <= vtsr_pkg::KIND_DISPLAY;
                end
                else if (is_blit)
                begin
                    res_kind_reg <= vtsr_pkg::KIND_BLIT;
                end
                else
                begin
                    res_kind_reg <= vtsr_pkg::KIND_ACK;
                end
            end
            else if (cmd.emit_en)
            begin
                second_reg <= 1'b0;
            end
            if (cmd.emit_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            maprow_reg <= maprow_next;
            rrow_reg   <= rrow_next;
            col_reg    <= col_next;
        end
        else if (cmd.emit_en && second_reg)
        begin
            col_reg <= col_reg + 1'b1;
        end
        if (cmd.index_en)
        begin
            prod_reg     <= vtsr_pkg::MAP_AW'(prod_full);
            dst_base_reg <= vtsr_pkg::OFS_W'(32'(rrow_reg >> vtsr_pkg::TILE_SHIFT) *
                                             vtsr_pkg::DST_ROW_BYTES);
        end
        if (cmd.scale_en)
        begin
            tile_reg <= rdata;
            q0_reg   <= recip_prod[vtsr_pkg::RECIP_SHIFT +: vtsr_pkg::TILE_W];
        end
        if (cmd.emit_en)
        begin
            kind_reg <= res_kind_reg;
            src_reg  <= '0;
            dst_reg  <= '0;
            top_reg  <= '0;
            fh_reg   <= '0;
            fl_reg   <= '0;
            sh_reg   <= '0;
            sl_reg   <= '0;
            last_reg <= 1'b1;
            if (res_kind_reg == vtsr_pkg::KIND_BLIT)
            begin
                src_reg  <= src_val;
                dst_reg  <= dst_val;
                last_reg <= !second_reg;
            end
            else if (res_kind_reg == vtsr_pkg::KIND_DISPLAY)
            begin
                top_reg <= top_val;
                fh_reg  <= (line > vtsr_pkg::LINE_W'(vtsr_pkg::LINE_WRAP)) ?
                           vtsr_pkg::WAIT_PAST_END : vtsr_pkg::WAIT_PLAIN;
                fl_reg  <= {line_m1[7:0], vtsr_pkg::WAIT_LOW_TAIL};
                sh_reg  <= (line == vtsr_pkg::LINE_W'(vtsr_pkg::LINE_WRAP)) ?
                           vtsr_pkg::WAIT_PAST_END : vtsr_pkg::WAIT_PLAIN;
                sl_reg  <= {line[7:0], vtsr_pkg::WAIT_LOW_TAIL};
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign source_offset    = src_reg;
    assign dest_offset      = dst_reg;
    assign top_offset       = top_reg;
    assign first_wait_high  = fh_reg;
    assign first_wait_low   = fl_reg;
    assign second_wait_high = sh_reg;
    assign second_wait_low  = sl_reg;
    assign last             = last_reg;

endmodule

`default_nettype wire

>>> rtl/core/vertical_tile_scroll_refresher_core.sv
// Top level of the vertical tile scroll refresher: controller plus datapath.
// Depends on vtsr_pkg, vtsr_ctrl, vtsr_datapath and the assertion macro header.
//
// One item is worked at a time. A map write or a frame update goes from its accept
// straight to the output; a scroll step with a blit first passes the map store read
// (address multiply, registered RAM read, tile-to-sheet scaling), and a second blit
// repeats the RAM read and scaling. The output is registered, so the next item is
// accepted while the last result of the previous one waits to be taken. The map
// store needs no clearing after reset; configuration writes are taken in any cycle.
`default_nettype none

`include "vertical_tile_scroll_refresher_core_macros.svh"

module vertical_tile_scroll_refresher_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [vtsr_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [vtsr_pkg::CMD_W-1:0]  command,
    input  wire logic [vtsr_pkg::ADDR_W-1:0] map_address,
    input  wire logic [vtsr_pkg::TILE_W-1:0] map_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [vtsr_pkg::KIND_W-1:0] kind,
    output logic      [vtsr_pkg::OFS_W-1:0]  source_offset,
    output logic      [vtsr_pkg::OFS_W-1:0]  dest_offset,
    output logic      [vtsr_pkg::OFS_W-1:0]  top_offset,
    output logic      [vtsr_pkg::OFS_W-1:0]  first_wait_high,
    output logic      [vtsr_pkg::OFS_W-1:0]  first_wait_low,
    output logic      [vtsr_pkg::OFS_W-1:0]  second_wait_high,
    output logic      [vtsr_pkg::OFS_W-1:0]  second_wait_low,
    output logic                             last
);

    vtsr_pkg::ctrl_cmd_t  cmd;
    vtsr_pkg::dp_status_t st;

    assign cfg_ready = 1'b1;

    vtsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    vtsr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .map_address      (map_address),
        .map_value        (map_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .source_offset    (source_offset),
        .dest_offset      (dest_offset),
        .top_offset       (top_offset),
        .first_wait_high  (first_wait_high),
        .first_wait_low   (first_wait_low),
        .second_wait_high (second_wait_high),
        .second_wait_low  (second_wait_low),
        .last             (last)
    );

    `VTSR_ASSERT_IMPLY(a_first_blit_keeps_busy, out_valid && !last, !in_ready, "busy lost with a non-final beat pending")
    `VTSR_ASSERT_IMPLY(a_only_blits_pair, out_valid && (kind != vtsr_pkg::KIND_BLIT), last, "non-blit beat not final")
    `VTSR_ASSERT_NEXT(a_emit_fills_output, cmd.emit_en, out_valid, "emitted beat not presented")

endmodule

`default_nettype wire
